@@ hw/rtl/isaac32_random_generator_defines.svh @@
// Assertion macros for the file that checks this block.
`ifndef ISAAC32_RANDOM_GENERATOR_DEFINES_SVH
`define ISAAC32_RANDOM_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISAAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isaac check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISAAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isaac check failed");

`endif

@@ hw/rtl/isaac_pkg.sv @@
package isaac_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [1:0] {
        REQ_DRAW   = 2'd0,
        REQ_SEED   = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_SEED,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op   kind;
        logic  clr;     // pool must be cleared first
        t_word word;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    localparam t_word GOLDEN = 32'h9e3779b9;

    // Shift term of scramble step k.
    function automatic t_word scr_shift(logic [2:0] k, t_word v);
        t_word r;
        unique case (k)
            3'd0: r = v << 11;
            3'd1: r = v >> 2;
            3'd2: r = v << 8;
            3'd3: r = v >> 16;
            3'd4: r = v << 10;
            3'd5: r = v >> 4;
            3'd6: r = v << 8;
            3'd7: r = v >> 9;
            default: r = v;
        endcase
        return r;
    endfunction

    // Accumulator twist, selected by the low two bits of the word index.
    function automatic t_word acc_twist(logic [1:0] k, t_word a);
        t_word r;
        unique case (k)
            2'd0: r = a << 13;
            2'd1: r = a >> 6;
            2'd2: r = a << 2;
            2'd3: r = a >> 16;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/isaac_front.sv @@
module isaac_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ready_en,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req,
    input  isaac_pkg::t_word   i_word,
    output isaac_pkg::t_qhead  o_head,
    input  logic               i_pop
);
    import isaac_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       r_seeding;

    logic accept, keep, push;
    t_cmd cmd;

    assign o_ready = i_ready_en && (r_cnt != 2'd2);
    assign accept  = i_valid && o_ready;

    // Draws while seeding and the unused code are dropped here.
    always_comb begin
        cmd.word = i_word;
        cmd.clr  = !r_seeding;
        cmd.kind = OP_DRAW;
        keep     = 1'b0;
        unique case (t_req'(i_req))
            REQ_DRAW:   begin cmd.kind = OP_DRAW;   keep = !r_seeding; end
            REQ_SEED:   begin cmd.kind = OP_SEED;   keep = 1'b1; end
            REQ_FINISH: begin cmd.kind = OP_FINISH; keep = 1'b1; end
            default:    keep = 1'b0;
        endcase
    end

    assign push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
            r_seeding <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= !r_wp;
            end
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
            if (accept && t_req'(i_req) == REQ_SEED)   r_seeding <= 1'b1;
            if (accept && t_req'(i_req) == REQ_FINISH) r_seeding <= 1'b0;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

@@ hw/rtl/isaac_back.sv @@
module isaac_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isaac_pkg::t_qhead  i_head,
    output logic               o_pop,
    output logic               o_boot_done,
    output logic               o_valid,
    input  logic               i_ready,
    output isaac_pkg::t_word   o_data
);
    import isaac_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_SRD, S_SWR, S_INIT, S_SCR, S_ADDA, S_ADDB, S_WR,
        S_GS, S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_DRD, S_DOUT
    } t_state;

    t_state     r_state;
    t_cmd       r_cmd;
    logic [7:0] r_i;
    logic [2:0] r_k;
    logic [1:0] r_rnd;
    logic       r_pre, r_pass2;
    t_word      r_mix [8];
    t_word      r_acc, r_last, r_cnt, r_x, r_y;
    logic [8:0] r_pos;
    logic [7:0] r_spos;
    logic       r_boot_done;
    logic       r_out_valid;
    t_word      r_out_data;

    t_word      pool_mem [256];
    t_word      state_mem [256];
    t_word      r_pool_rd, r_mem_rd;

    logic       pool_we, mem_we;
    logic [7:0] pool_wa, pool_ra, mem_wa, mem_ra;
    t_word      pool_wd, mem_wd;

    t_word      stp [8];
    t_word      n_y, n_last;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (pool_we) pool_mem[pool_wa] <= pool_wd;
        r_pool_rd <= pool_mem[pool_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) state_mem[mem_wa] <= mem_wd;
        r_mem_rd <= state_mem[mem_ra];
    end

    assign n_y    = r_mem_rd + r_acc + r_last;
    assign n_last = r_mem_rd + r_x;

    // One scramble step on the rotated register file: a=0, b=1, c=2, d=3.
    always_comb begin
        for (int m = 0; m < 8; m++) stp[m] = r_mix[m];
        stp[0] = r_mix[0] ^ scr_shift(r_k, r_mix[1]);
        stp[3] = r_mix[3] + stp[0];
        stp[1] = r_mix[1] + r_mix[2];
    end

    always_comb begin
        pool_we = 1'b0;
        pool_wa = r_i;
        pool_wd = '0;
        pool_ra = r_pos[7:0];
        mem_we  = 1'b0;
        mem_wa  = r_i;
        mem_wd  = r_mix[0];
        mem_ra  = r_i;
        unique case (r_state)
            S_CLR: pool_we = 1'b1;
            S_SRD: pool_ra = r_spos;
            S_SWR: begin
                pool_we = 1'b1;
                pool_wa = r_spos;
                pool_wd = r_pool_rd ^ r_cmd.word;
            end
            S_ADDA: pool_ra = r_i;
            S_WR:   mem_we = 1'b1;
            S_G1:   mem_ra = r_i + 8'd128;
            S_G2:   mem_ra = r_x[9:2];
            S_G3: begin
                mem_we = 1'b1;
                mem_wd = n_y;
            end
            S_G4: mem_ra = r_y[17:10];
            S_G5: begin
                pool_we = 1'b1;
                pool_wd = n_last;
            end
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLR;
            r_cmd.kind       <= OP_FINISH;
            r_cmd.clr        <= 1'b1;
            r_i              <= '0;
            r_pos            <= '0;
            r_spos           <= '0;
            r_boot_done      <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DOUT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd <= i_head.cmd;
                        r_i   <= '0;
                        unique case (i_head.cmd.kind)
                            OP_DRAW:   r_state <= r_pos[8] ? S_GS : S_DRD;
                            OP_SEED: begin
                                if (i_head.cmd.clr) r_spos <= '0;
                                r_state <= i_head.cmd.clr ? S_CLR : S_SRD;
                            end
                            OP_FINISH: r_state <= i_head.cmd.clr ? S_CLR : S_INIT;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLR: begin
                    r_i <= r_i + 8'd1;
                    if (r_i == 8'd255)
                        r_state <= (r_cmd.kind == OP_SEED) ? S_SRD : S_INIT;
                end
                S_SRD: r_state <= S_SWR;
                S_SWR: begin
                    r_spos  <= r_spos + 8'd1;
                    r_state <= S_IDLE;
                end
                S_INIT: begin
                    r_acc   <= '0;
                    r_last  <= '0;
                    r_cnt   <= '0;
                    for (int m = 0; m < 8; m++) r_mix[m] <= GOLDEN;
                    r_k     <= '0;
                    r_rnd   <= '0;
                    r_pre   <= 1'b1;
                    r_pass2 <= 1'b0;
                    r_i     <= '0;
                    r_state <= S_SCR;
                end
                S_SCR: begin
                    for (int m = 0; m < 8; m++) r_mix[m] <= stp[3'(m + 1)];
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        if (r_pre) begin
                            r_rnd <= r_rnd + 2'd1;
                            if (r_rnd == 2'd3) begin
                                r_pre   <= 1'b0;
                                r_state <= S_ADDA;
                            end
                        end else begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_ADDA: r_state <= S_ADDB;
                S_ADDB: begin
                    // Second pass folds the memory back in instead of the pool.
                    for (int m = 0; m < 7; m++) r_mix[m] <= r_mix[m + 1];
                    r_mix[7] <= r_mix[0] + (r_pass2 ? r_mem_rd : r_pool_rd);
                    if (r_i[2:0] == 3'd7) begin
                        r_i     <= r_i - 8'd7;
                        r_state <= S_SCR;
                    end else begin
                        r_i     <= r_i + 8'd1;
                        r_state <= S_ADDA;
                    end
                end
                S_WR: begin
                    for (int m = 0; m < 8; m++) r_mix[m] <= r_mix[3'(m + 1)];
                    r_i <= r_i + 8'd1;
                    if (r_i[2:0] == 3'd7) begin
                        if (r_i == 8'd255) begin
                            r_pass2 <= 1'b1;
                            r_state <= r_pass2 ? S_GS : S_ADDA;
                        end else begin
                            r_state <= S_ADDA;
                        end
                    end
                end
                S_GS: begin
                    r_cnt   <= r_cnt + 32'd1;
                    r_last  <= r_last + r_cnt + 32'd1;
                    r_i     <= '0;
                    r_state <= S_G0;
                end
                S_G0: r_state <= S_G1;
                S_G1: begin
                    r_x     <= r_mem_rd;
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_acc   <= (r_acc ^ acc_twist(r_i[1:0], r_acc)) + r_mem_rd;
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_y     <= n_y;
                    r_state <= S_G4;
                end
                S_G4: r_state <= S_G5;
                S_G5: begin
                    r_last <= n_last;
                    r_i    <= r_i + 8'd1;
                    if (r_i == 8'd255) begin
                        r_pos <= '0;
                        if (r_cmd.kind == OP_DRAW) begin
                            r_state <= S_DRD;
                        end else begin
                            r_spos      <= '0;
                            r_boot_done <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_G0;
                    end
                end
                S_DRD: r_state <= S_DOUT;
                S_DOUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_pool_rd;
                        r_pos       <= r_pos + 9'd1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_boot_done = r_boot_done;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

endmodule

@@ hw/rtl/isaac32_random_generator.sv @@
// ISAAC 32-bit generator. The item kind (tuser) selects a draw, a seed word or
// a finish. After reset the block runs an empty-seed initialization, during
// which it takes no item. A draw reads the next pool word into the output
// register; a draw that finds all 256 pool words used first regenerates the
// pool word by word, paced by the single read port of the internal memory
// and its four reads per word. The first seed word of a seed run first
// clears the pool. A finish (after the clear for an empty seed) runs mostly
// the two mixing passes over groups of eight words, then fills the pool. A
// two-entry queue holds items while the back end is busy, and the output
// register lets the next item in while a result waits.
module isaac32_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] seed_word
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] random_value
);
    import isaac_pkg::*;
    `include "isaac32_random_generator_defines.svh"

    t_qhead w_head;
    logic   w_pop;
    logic   w_boot_done;

    isaac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ready_en (w_boot_done),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_req      (i_s_axis_tuser),
        .i_word     (i_s_axis_tdata),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    isaac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_boot_done (w_boot_done),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

    `ISAAC_ASSERT_SAME(a_no_input_during_boot, i_clk, i_rst_n, !w_boot_done, !o_s_axis_tready)
    `ISAAC_ASSERT_SAME(a_pop_only_when_queued, i_clk, i_rst_n, w_pop, w_head.valid)
    `ISAAC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

endmodule

@@ sim/tb.sv @@
module tb;
    import isaac_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;   // [31:0] seed_word
    logic [1:0]  s_user;   // [1:0] req_type
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;   // [31:0] random_value

    isaac32_random_generator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // Generator state as the block should hold it.
    t_word      pool_q [256];
    t_word      mem_q [256];
    t_word      mix_q [8];
    t_word      acc_q;
    t_word      last_q;
    t_word      blocks_q;
    logic [8:0] draw_pos_q;
    logic [7:0] seed_pos_q;
    logic       seeding_q;

    t_word      expected_words [$];
    int         n_errors;
    int         n_checked;
    int         n_items;
    int         n_finishes;
    int         cycles;
    bit         tx_idle;
    bit         rx_idle;
    int         rx_hold;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic void scramble_mix();
        mix_q[0] ^= mix_q[1] << 11; mix_q[3] += mix_q[0]; mix_q[1] += mix_q[2];
        mix_q[1] ^= mix_q[2] >> 2;  mix_q[4] += mix_q[1]; mix_q[2] += mix_q[3];
        mix_q[2] ^= mix_q[3] << 8;  mix_q[5] += mix_q[2]; mix_q[3] += mix_q[4];
        mix_q[3] ^= mix_q[4] >> 16; mix_q[6] += mix_q[3]; mix_q[4] += mix_q[5];
        mix_q[4] ^= mix_q[5] << 10; mix_q[7] += mix_q[4]; mix_q[5] += mix_q[6];
        mix_q[5] ^= mix_q[6] >> 4;  mix_q[0] += mix_q[5]; mix_q[6] += mix_q[7];
        mix_q[6] ^= mix_q[7] << 8;  mix_q[1] += mix_q[6]; mix_q[7] += mix_q[0];
        mix_q[7] ^= mix_q[0] >> 9;  mix_q[2] += mix_q[7]; mix_q[0] += mix_q[1];
    endfunction

    function automatic void refill_pool();
        t_word x;
        t_word y;
        t_word tw;
        blocks_q += 1;
        last_q += blocks_q;
        for (int i = 0; i < 256; i++) begin
            x = mem_q[i];
            case (i % 4)
                0: tw = acc_q << 13;
                1: tw = acc_q >> 6;
                2: tw = acc_q << 2;
                default: tw = acc_q >> 16;
            endcase
            acc_q = (acc_q ^ tw) + mem_q[(i + 128) % 256];
            y = mem_q[(x >> 2) & 8'hff] + acc_q + last_q;
            mem_q[i] = y;
            last_q = mem_q[(y >> 10) & 8'hff] + x;
            pool_q[i] = last_q;
        end
        draw_pos_q = '0;
    endfunction

    function automatic void seed_generator();
        for (int i = 0; i < 256; i++) mem_q[i] = '0;
        acc_q = '0;
        last_q = '0;
        blocks_q = '0;
        for (int j = 0; j < 8; j++) mix_q[j] = GOLDEN;
        for (int i = 0; i < 4; i++) scramble_mix();
        for (int i = 0; i < 256; i += 8) begin
            for (int j = 0; j < 8; j++) mix_q[j] += pool_q[i + j];
            scramble_mix();
            for (int j = 0; j < 8; j++) mem_q[i + j] = mix_q[j];
        end
        for (int i = 0; i < 256; i += 8) begin
            for (int j = 0; j < 8; j++) mix_q[j] += mem_q[i + j];
            scramble_mix();
            for (int j = 0; j < 8; j++) mem_q[i + j] = mix_q[j];
        end
        refill_pool();
        seed_pos_q = '0;
        seeding_q = 1'b0;
    endfunction

    // Applies one accepted item and queues the word a draw should return.
    function automatic void predict_item(t_req kind, t_word word);
        if (kind == REQ_SEED) begin
            if (!seeding_q) begin
                for (int i = 0; i < 256; i++) pool_q[i] = '0;
                seed_pos_q = '0;
                seeding_q = 1'b1;
            end
            pool_q[seed_pos_q] ^= word;
            seed_pos_q += 1;
        end else if (kind == REQ_FINISH) begin
            if (!seeding_q)
                for (int i = 0; i < 256; i++) pool_q[i] = '0;
            seed_generator();
        end else if (kind == REQ_DRAW && !seeding_q) begin
            if (draw_pos_q >= 256) refill_pool();
            expected_words.push_back(pool_q[draw_pos_q[7:0]]);
            draw_pos_q += 1;
        end
    endfunction

    task automatic send_item(t_req kind, t_word word);
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= word;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_item(kind, word);
        n_items++;
        if (kind == REQ_FINISH) n_finishes++;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic release_bus();
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_after_reset();
        for (int i = 0; i < 4; i++) send_item(REQ_DRAW, $urandom);
        release_bus();
    endtask

    task automatic test_directed();
        send_item(REQ_SEED, 32'hffff_ffff);
        send_item(REQ_SEED, 32'h0000_0000);
        send_item(REQ_DRAW, 32'h1234_5678);   // dropped while seeding
        send_item(REQ_NONE, 32'hdead_beef);   // unused code
        send_item(REQ_SEED, 32'h8000_0001);
        send_item(REQ_FINISH, 32'hffff_ffff);
        for (int i = 0; i < 4; i++) send_item(REQ_DRAW, 32'hffff_ffff);
        send_item(REQ_NONE, 32'h0);
        // Finish with no seed words: empty-seed initialization.
        send_item(REQ_FINISH, 32'h0);
        for (int i = 0; i < 4; i++) send_item(REQ_DRAW, 32'h0);
        send_item(REQ_SEED, 32'h0);
        send_item(REQ_FINISH, 32'h0);
        send_item(REQ_DRAW, 32'h0);
        release_bus();
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold = 600;
        for (int i = 0; i < 12; i++) send_item(REQ_DRAW, $urandom);
        release_bus();
    endtask

    // Long seed wraps the pool position; long draw run forces a refill.
    task automatic test_wrap_and_refill();
        for (int i = 0; i < 260; i++) send_item(REQ_SEED, $urandom);
        send_item(REQ_FINISH, $urandom);
        for (int i = 0; i < 264; i++) send_item(REQ_DRAW, $urandom);
        release_bus();
    endtask

    task automatic test_random(int count);
        int n;
        while (count > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) send_item(REQ_SEED, $urandom);
                if ($urandom_range(0, 4) == 0) send_item(REQ_DRAW, $urandom);
                send_item(REQ_FINISH, $urandom);
                n = n + 1 + $urandom_range(1, 20);
                for (int i = 0; i < n - 1; i++) send_item(REQ_DRAW, $urandom);
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_item(t_req'($urandom_range(0, 3)), $urandom);
            end
            count -= n;
        end
        release_bus();
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %08h", $time, m_data);
                n_errors++;
            end else begin
                if (m_data !== expected_words[0]) begin
                    $display("%0t: random_value mismatch, expected %08h, actual %08h",
                             $time, expected_words[0], m_data);
                    n_errors++;
                end
                void'(expected_words.pop_front());
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time,
                     expected_words.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        n_errors = 0;
        n_checked = 0;
        n_items = 0;
        n_finishes = 0;
        cycles = 0;
        rx_hold = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        s_valid = 1'b0;
        s_user = REQ_NONE;
        s_data = '0;
        for (int i = 0; i < 256; i++) pool_q[i] = '0;
        seed_generator();
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_directed();
        test_backpressure();
        test_wrap_and_refill();
        test_random(75);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random(25);

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Ran %0d items with %0d initializations; %0d random words compared.",
                 n_items, n_finishes, n_checked);
        $display("Covered seeding, wrapped seeds, ignored draws, pool refills and stalls.");
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
